### rtl/core/svg_pkg.sv
package svg_pkg;

	// field widths
	localparam int TURNS_W  = 8;
	localparam int SPT_W    = 10;
	localparam int RAD_W    = 15;
	localparam int COORD_W  = 16;
	localparam int VIDX_W   = 18;
	localparam int TOTAL_W  = TURNS_W + SPT_W;
	localparam int PHASE_W  = 32;
	localparam int GAIN_W   = 32;

	// datapath widths for the rotation
	localparam int XY_W = 34;
	localparam int Z_W  = 34;

	// parameter defaults
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int INDEX_BITS_DEF    = 18;

	// register map
	localparam int REG_ADDR_W = 5;
	localparam logic [2:0] REG_TURNS    = 3'd0;
	localparam logic [2:0] REG_SPT      = 3'd1;
	localparam logic [2:0] REG_RADIUS   = 3'd2;
	localparam logic [2:0] REG_CENTER_X = 3'd3;
	localparam logic [2:0] REG_CENTER_Y = 3'd4;

	// reset values
	localparam logic [TURNS_W-1:0] TURNS_RST  = 8'd5;
	localparam logic [SPT_W-1:0]   SPT_RST    = 10'd100;
	localparam logic [RAD_W-1:0]   RADIUS_RST = 15'd9830;

	// cordic gain 0.60725293 in Q32
	localparam logic [GAIN_W-1:0] CORDIC_GAIN = 32'd2608131496;

	// quarter turn in binary angle units
	localparam logic signed [Z_W-1:0] QUARTER = Z_W'(64'sh40000000);
	localparam logic signed [Z_W-1:0] HALF    = Z_W'(64'sh80000000);

	typedef struct packed {
		logic zero_total;
		logic beyond;
		logic final_vtx;
	} svg_flags_t;

	localparam int FLAGS_W = $bits(svg_flags_t);

	// atan(2^-i) in binary angle units, zero past the table
	function automatic logic [PHASE_W-1:0] atan_angle(input int i);
		logic [PHASE_W-1:0] a;
		case (i)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### rtl/core/svg_in_if.sv
interface svg_in_if;
	logic                        valid;
	logic                        ready;
	logic [svg_pkg::VIDX_W-1:0]  vertex_index;

	modport source (output valid, output vertex_index, input ready);
	modport sink   (input valid, input vertex_index, output ready);
endinterface

### rtl/core/svg_out_if.sv
interface svg_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [svg_pkg::COORD_W-1:0] pos_x;
	logic signed [svg_pkg::COORD_W-1:0] pos_y;
	logic                               final_vertex;
	logic                               beyond_end;

	modport source (output valid, output pos_x, output pos_y, output final_vertex,
		output beyond_end, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input final_vertex,
		input beyond_end, output ready);
endinterface

### rtl/core/svg_div.sv
// pipelined restoring divider, one quotient bit per stage
module svg_div #(
	parameter int DW = 10,
	parameter int QW = 16,
	parameter int SW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_word,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quot,
	output logic [DW-1:0] out_rem,
	output logic [SW-1:0] out_side
);
	logic          v_s    [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] word_s [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          pv;
		logic [DW-1:0] prem;
		logic [QW-1:0] pword;
		logic [SW-1:0] pside;
		logic [DW:0]   trial;
		logic          ge;
		logic [DW:0]   diff;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = in_rem;
			assign pword = in_word;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign pword = word_s[k-1];
			assign pside = side_s[k-1];
		end

		// shift in the next dividend bit and try a subtract
		assign trial = {prem, pword[QW-1]};
		assign ge    = trial >= {1'b0, divisor};
		assign diff  = trial - {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				word_s[k] <= {pword[QW-2:0], ge};
				side_s[k] <= pside;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_quot  = word_s[QW-1];
	assign out_rem   = rem_s[QW-1];
	assign out_side  = side_s[QW-1];
endmodule

### rtl/core/spiral_vertex_generator.sv
// channel   dir  payload                                         handshake
// vtx_in    in   vertex_index                                    valid/ready
// vtx_out   out  pos_x, pos_y, final_vertex, beyond_end          valid/ready
// apb       in   num_turns, segments_per_turn, max_radius, center  psel/penable
//
// one item per clock while the output is not stalled; an item passes stage 1, the
// three bit-per-stage dividers (index mod segments, radius, phase), stages 2 and 3,
// one stage per cordic rotation and the output register.
// arst_n clears the valid bits and loads the register reset values.
// a stalled output freezes the whole pipeline; no item is lost or repeated.
module spiral_vertex_generator #(
	parameter int CORDIC_STAGES = svg_pkg::CORDIC_STAGES_DEF,
	parameter int INDEX_BITS    = svg_pkg::INDEX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [svg_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	svg_in_if.sink                         vtx_in,
	svg_out_if.source                      vtx_out
);
	import svg_pkg::*;

	localparam int NUMR_W = RAD_W + INDEX_BITS + 1;
	localparam int RS_W   = RAD_W + INDEX_BITS;

	// configuration registers
	logic [TURNS_W-1:0]        turns_q;
	logic [SPT_W-1:0]          spt_q;
	logic [RAD_W-1:0]          radius_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic                      wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turns_q  <= TURNS_RST;
			spt_q    <= SPT_RST;
			radius_q <= RADIUS_RST;
			cx_q     <= '0;
			cy_q     <= '0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_TURNS:    turns_q  <= pwdata[TURNS_W-1:0];
				REG_SPT:      spt_q    <= pwdata[SPT_W-1:0];
				REG_RADIUS:   radius_q <= pwdata[RAD_W-1:0];
				REG_CENTER_X: cx_q     <= pwdata[COORD_W-1:0];
				REG_CENTER_Y: cy_q     <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:2])
			REG_TURNS:    prdata = 32'(turns_q);
			REG_SPT:      prdata = 32'(spt_q);
			REG_RADIUS:   prdata = 32'(radius_q);
			REG_CENTER_X: prdata = 32'(unsigned'(cx_q));
			REG_CENTER_Y: prdata = 32'(unsigned'(cy_q));
			default:      prdata = '0;
		endcase
	end

	// global advance: move when the output slot is free or being taken
	logic en;
	logic out_v_q;

	assign en           = !out_v_q || vtx_out.ready;
	assign vtx_in.ready = en;

	logic [TOTAL_W-1:0] total;
	assign total = TOTAL_W'(turns_q) * TOTAL_W'(spt_q);

	// stage 1: index, radius numerator, flags
	logic [INDEX_BITS-1:0] n_in;
	logic [NUMR_W-1:0]     numr_in;
	logic                  v_s1;
	logic [INDEX_BITS-1:0] n_s1;
	logic [NUMR_W-1:0]     numr_s1;
	svg_flags_t            fl_s1;

	assign n_in    = INDEX_BITS'(vtx_in.vertex_index);
	assign numr_in = NUMR_W'(RS_W'(radius_q) * RS_W'(n_in)) + NUMR_W'(total >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vtx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1                <= n_in;
			numr_s1             <= numr_in;
			fl_s1.zero_total    <= total == '0;
			fl_s1.beyond        <= TOTAL_W'(n_in) > total || (INDEX_BITS'(total) != n_in
				&& (n_in >> TOTAL_W) != '0);
			fl_s1.final_vtx     <= (TOTAL_W'(n_in) == total) && ((n_in >> TOTAL_W) == '0);
		end
	end

	// index mod segments_per_turn
	logic                       v_md;
	logic [SPT_W-1:0]           m_md;
	logic [INDEX_BITS-1:0]      q_md;
	logic [NUMR_W+FLAGS_W-1:0]  side_md;

	svg_div #(.DW(SPT_W), .QW(INDEX_BITS), .SW(NUMR_W + FLAGS_W)) u_mod (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_rem('0), .in_word(n_s1), .divisor(spt_q),
		.in_side({numr_s1, fl_s1}),
		.out_valid(v_md), .out_quot(q_md), .out_rem(m_md), .out_side(side_md)
	);

	// radius = rounded numerator / total
	logic [NUMR_W-1:0]          numr_md;
	logic [FLAGS_W-1:0]         flv_md;
	logic                       v_rd;
	logic [RAD_W-1:0]           r_rd;
	logic [TOTAL_W-1:0]         rem_rd;
	logic [SPT_W+FLAGS_W-1:0]   side_rd;

	assign {numr_md, flv_md} = side_md;

	svg_div #(.DW(TOTAL_W), .QW(RAD_W), .SW(SPT_W + FLAGS_W)) u_radius (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_md), .in_rem(TOTAL_W'(numr_md >> RAD_W)), .in_word(numr_md[RAD_W-1:0]),
		.divisor(total), .in_side({m_md, flv_md}),
		.out_valid(v_rd), .out_quot(r_rd), .out_rem(rem_rd), .out_side(side_rd)
	);

	// phase = rounded (m * 2^32) / segments_per_turn
	logic [SPT_W-1:0]           m_rd;
	logic [FLAGS_W-1:0]         flv_rd;
	logic                       v_ph;
	logic [PHASE_W-1:0]         p_ph;
	logic [SPT_W-1:0]           rem_ph;
	logic [RAD_W+FLAGS_W-1:0]   side_ph;

	assign {m_rd, flv_rd} = side_rd;

	svg_div #(.DW(SPT_W), .QW(PHASE_W), .SW(RAD_W + FLAGS_W)) u_phase (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_rd), .in_rem(m_rd), .in_word(PHASE_W'(spt_q >> 1)),
		.divisor(spt_q), .in_side({r_rd, flv_rd}),
		.out_valid(v_ph), .out_quot(p_ph), .out_rem(rem_ph), .out_side(side_ph)
	);

	// stage 2: radius times cordic gain
	localparam int PROD_W = RAD_W + GAIN_W;
	logic [RAD_W-1:0]         r_ph;
	logic [FLAGS_W-1:0]       flv_ph;
	logic [PROD_W-1:0]        prod;
	logic                     v_s2;
	logic signed [XY_W-1:0]   x_s2;
	logic signed [Z_W-1:0]    z_s2;
	svg_flags_t               fl_s2;

	assign {r_ph, flv_ph} = side_ph;
	assign prod = PROD_W'(r_ph) * PROD_W'(CORDIC_GAIN) + PROD_W'(33'h8000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_ph;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2  <= signed'(XY_W'(prod >> 16));
			z_s2  <= Z_W'(signed'(p_ph));
			fl_s2 <= svg_flags_t'(flv_ph);
		end
	end

	// stage 3: fold the angle into the right half plane
	logic                     v_s3;
	logic signed [XY_W-1:0]   x_s3;
	logic signed [Z_W-1:0]    z_s3;
	svg_flags_t               fl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s3 <= fl_s2;
			if (z_s2 > QUARTER) begin
				z_s3 <= z_s2 - HALF;
				x_s3 <= -x_s2;
			end else if (z_s2 < -QUARTER) begin
				z_s3 <= z_s2 + HALF;
				x_s3 <= -x_s2;
			end else begin
				z_s3 <= z_s2;
				x_s3 <= x_s2;
			end
		end
	end

	// cordic rotation, one step per stage
	logic                   v_c  [CORDIC_STAGES];
	logic signed [XY_W-1:0] x_c  [CORDIC_STAGES];
	logic signed [XY_W-1:0] y_c  [CORDIC_STAGES];
	logic signed [Z_W-1:0]  z_c  [CORDIC_STAGES];
	svg_flags_t             fl_c [CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		localparam logic signed [Z_W-1:0] ANG = signed'(Z_W'(atan_angle(i)));
		logic                   pv;
		logic signed [XY_W-1:0] px;
		logic signed [XY_W-1:0] py;
		logic signed [Z_W-1:0]  pz;
		svg_flags_t             pf;

		if (i == 0) begin : g_first
			assign pv = v_s3;
			assign px = x_s3;
			assign py = '0;
			assign pz = z_s3;
			assign pf = fl_s3;
		end else begin : g_next
			assign pv = v_c[i-1];
			assign px = x_c[i-1];
			assign py = y_c[i-1];
			assign pz = z_c[i-1];
			assign pf = fl_c[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c[i] <= 1'b0;
			end else if (en) begin
				v_c[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fl_c[i] <= pf;
				if (pz >= 0) begin
					x_c[i] <= px - (py >>> i);
					y_c[i] <= py + (px >>> i);
					z_c[i] <= pz - ANG;
				end else begin
					x_c[i] <= px + (py >>> i);
					y_c[i] <= py - (px >>> i);
					z_c[i] <= pz + ANG;
				end
			end
		end
	end

	// output stage: round, offset by center, saturate; center alone when beyond end or zero total
	localparam int RND_W = XY_W - 16;
	localparam int SUM_W = RND_W + 2;

	logic signed [XY_W-1:0]  xr_full;
	logic signed [XY_W-1:0]  yr_full;
	logic signed [SUM_W-1:0] xs;
	logic signed [SUM_W-1:0] ys;
	logic signed [COORD_W-1:0] x_sat;
	logic signed [COORD_W-1:0] y_sat;
	svg_flags_t                fl_last;
	logic                      use_center;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

	assign fl_last    = fl_c[CORDIC_STAGES-1];
	assign use_center = fl_last.beyond || fl_last.zero_total;
	assign xr_full    = (x_c[CORDIC_STAGES-1] + XY_W'(32768)) >>> 16;
	assign yr_full    = (y_c[CORDIC_STAGES-1] + XY_W'(32768)) >>> 16;
	assign xs = SUM_W'(signed'(xr_full[RND_W-1:0])) + SUM_W'(cx_q);
	assign ys = SUM_W'(signed'(yr_full[RND_W-1:0])) + SUM_W'(cy_q);

	always_comb begin
		if (xs > SAT_HI) begin
			x_sat = 16'sh7FFF;
		end else if (xs < SAT_LO) begin
			x_sat = -16'sh8000;
		end else begin
			x_sat = xs[COORD_W-1:0];
		end
		if (ys > SAT_HI) begin
			y_sat = 16'sh7FFF;
		end else if (ys < SAT_LO) begin
			y_sat = -16'sh8000;
		end else begin
			y_sat = ys[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_c[CORDIC_STAGES-1];
		end
	end

	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] py_q;
	logic                      fin_q;
	logic                      bey_q;

	always_ff @(posedge clk) begin
		if (en) begin
			px_q  <= use_center ? cx_q : x_sat;
			py_q  <= use_center ? cy_q : y_sat;
			fin_q <= fl_last.final_vtx;
			bey_q <= fl_last.beyond;
		end
	end

	assign vtx_out.valid        = out_v_q;
	assign vtx_out.pos_x        = px_q;
	assign vtx_out.pos_y        = py_q;
	assign vtx_out.final_vertex = fin_q;
	assign vtx_out.beyond_end   = bey_q;
endmodule
